// File: rtl/lru_page_replacement_unit_macros.svh
// assertion macros for the lru page replacement unit
// no dependencies; included by modules that carry concurrent checks
`ifndef LRU_PAGE_REPLACEMENT_UNIT_MACROS_SVH
`define LRU_PAGE_REPLACEMENT_UNIT_MACROS_SVH
`ifndef SYNTH
// property must hold at every clock edge outside reset
`define LPR_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("lpr check failed");
// expression must never be true outside reset
`define LPR_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("lpr forbidden condition seen");
`else
`define LPR_ASSERT(label, clk, rst_n, prop)
`define LPR_NEVER(label, clk, rst_n, expr)
`endif
`endif

// File: rtl/lpr_pkg.sv
// shared types and constants for the lru page replacement unit
// no dependencies
package lpr_pkg;

    // fixed field widths
    localparam int PAGE_W  = 16;
    localparam int FRAME_W = 4;
    localparam int FAULT_W = 32;
    localparam int CFG_W   = 5;

    // configuration reset and parameter defaults
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;
    localparam int MAX_FRAMES_DEF = 16;
    localparam int PAGE_BITS_DEF  = 16;

    localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

    // one reference beat
    typedef struct packed {
        logic [PAGE_W-1:0] page_number;
        logic              start_of_string;
        logic              end_of_string;
    } t_item;

    // one result beat
    typedef struct packed {
        logic               hit;
        logic [FRAME_W-1:0] frame_index;
        logic               evicted_valid;
        logic [PAGE_W-1:0]  evicted_page;
        logic [FAULT_W-1:0] fault_total;
        logic               final_result;
    } t_result;

endpackage

// File: rtl/lpr_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module lpr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/lru_page_replacement_unit.sv
// lru page replacement unit: top level with scan sequencer and recency ranks
// depends on lpr_pkg, lpr_ram and lru_page_replacement_unit_macros.svh
//
//  channel  direction  handshake                 payload
//  in       input      i_in_valid / o_in_stall   i_in_data  (t_item)
//  out      output     o_out_valid / i_out_stall o_out_data (t_result)
//  cfg      input      i_cfg_we                  i_cfg_data (frames_in_use)
//
// a reference passes the accept step, the scan and the update step; the scan issues
// one frame page read per cycle from the page ram for n frames, n being the active
// frame count (1..MAX_FRAMES), then evaluates the registered reads; the page ram read port sets the pace.
// reset (synchronous, active low) empties all frames, zeroes the fault count and
// sets frames_in_use to 16. a stalled result waits in the output register while
// the next reference is scanned; the update cycle waits until that register is free.
module lru_page_replacement_unit #(
    parameter int MAX_FRAMES = lpr_pkg::MAX_FRAMES_DEF,
    parameter int PAGE_BITS  = lpr_pkg::PAGE_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  lpr_pkg::t_item           i_in_data,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output lpr_pkg::t_result         o_out_data,
    input  logic                     i_cfg_we,
    input  logic [lpr_pkg::CFG_W-1:0] i_cfg_data
);

    import lpr_pkg::*;

    `include "lru_page_replacement_unit_macros.svh"

    localparam int IDX_W  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
    localparam int RANK_W = IDX_W;
    localparam int PW     = (PAGE_BITS < PAGE_W) ? PAGE_BITS : PAGE_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE
    } t_state;

    t_state              r_state;
    logic [CFG_W-1:0]    r_cfg;
    logic [CNT_W-1:0]    frames_lim;
    logic [CNT_W-1:0]    r_lim;

    logic [MAX_FRAMES-1:0] r_valid;
    logic [RANK_W-1:0]     r_rank [MAX_FRAMES];
    logic [CNT_W-1:0]      r_valid_cnt;
    logic [FAULT_W-1:0]    r_fault;

    logic [PW-1:0]       r_page;
    logic                r_eos;

    // scan pipeline
    logic [CNT_W-1:0]    r_rd_idx;
    logic                r_ev_vld;
    logic [IDX_W-1:0]    r_ev_idx;
    logic [PW-1:0]       ram_rdata;

    // scan findings
    logic                r_hit_found;
    logic [IDX_W-1:0]    r_hit_idx;
    logic [RANK_W-1:0]   r_hit_rank;
    logic                r_empty_found;
    logic [IDX_W-1:0]    r_empty_idx;
    logic                r_victim_found;
    logic [IDX_W-1:0]    r_victim_idx;
    logic [RANK_W-1:0]   r_victim_rank;
    logic [PW-1:0]       r_victim_page;

    t_result             r_out;
    logic                r_out_valid;

    logic                in_fire;
    logic                out_free;
    logic                upd_fire;
    logic                ev_valid;
    logic [RANK_W-1:0]   ev_rank;

    logic [IDX_W-1:0]    n_frame;
    logic                n_promote;
    logic [RANK_W-1:0]   n_old_rank;
    logic [RANK_W-1:0]   n_top_rank;
    logic [FAULT_W-1:0]  n_fault;
    logic                ram_we;

    assign in_fire  = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;
    assign upd_fire = (r_state == S_UPDATE) && out_free;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // clamp the configured frame count to 1..MAX_FRAMES
    always_comb begin
        if (r_cfg == '0) begin
            frames_lim = CNT_W'(1);
        end else if (int'(r_cfg) > MAX_FRAMES) begin
            frames_lim = CNT_W'(MAX_FRAMES);
        end else begin
            frames_lim = CNT_W'(r_cfg);
        end
    end

    // entry under evaluation this cycle
    assign ev_valid = r_valid[r_ev_idx];
    assign ev_rank  = r_rank[r_ev_idx];

    // update decisions
    always_comb begin
        if (r_hit_found) begin
            n_frame = r_hit_idx;
        end else if (r_empty_found) begin
            n_frame = r_empty_idx;
        end else begin
            n_frame = r_victim_idx;
        end
        n_promote  = r_hit_found || !r_empty_found;
        n_old_rank = r_hit_found ? r_hit_rank : r_victim_rank;
        n_top_rank = RANK_W'(r_valid_cnt - CNT_W'(1));
        if (!r_hit_found && (r_fault != FAULT_MAX)) begin
            n_fault = r_fault + FAULT_W'(1);
        end else begin
            n_fault = r_fault;
        end
    end

    assign ram_we = upd_fire && !r_hit_found;

    // frame page store
    lpr_ram #(
        .WIDTH(PW),
        .DEPTH(MAX_FRAMES)
    ) u_page_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(n_frame),
        .i_wdata(r_page),
        .i_raddr(r_rd_idx[IDX_W-1:0]),
        .o_rdata(ram_rdata)
    );

    // sequencer, frame state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg       <= CFG_RESET;
            r_valid     <= '0;
            r_valid_cnt <= '0;
            r_fault     <= '0;
            r_out_valid <= 1'b0;
            r_ev_vld    <= 1'b0;
            for (int i = 0; i < MAX_FRAMES; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_page         <= i_in_data.page_number[PW-1:0];
                        r_eos          <= i_in_data.end_of_string;
                        r_lim          <= frames_lim;
                        r_rd_idx       <= '0;
                        r_ev_vld       <= 1'b0;
                        r_hit_found    <= 1'b0;
                        r_empty_found  <= 1'b0;
                        r_victim_found <= 1'b0;
                        if (i_in_data.start_of_string) begin
                            r_valid     <= '0;
                            r_valid_cnt <= '0;
                            r_fault     <= '0;
                        end
                        r_state <= S_SCAN;
                    end
                end

                S_SCAN: begin
                    // issue one page read per cycle
                    if (r_rd_idx != r_lim) begin
                        r_rd_idx <= r_rd_idx + CNT_W'(1);
                        r_ev_idx <= r_rd_idx[IDX_W-1:0];
                        r_ev_vld <= 1'b1;
                    end else begin
                        // last entry is evaluated this cycle
                        r_ev_vld <= 1'b0;
                        r_state  <= S_UPDATE;
                    end
                    // evaluate the entry read last cycle
                    if (r_ev_vld) begin
                        if (ev_valid) begin
                            if (!r_hit_found && (ram_rdata == r_page)) begin
                                r_hit_found <= 1'b1;
                                r_hit_idx   <= r_ev_idx;
                                r_hit_rank  <= ev_rank;
                            end
                            if (!r_victim_found || (ev_rank < r_victim_rank)) begin
                                r_victim_found <= 1'b1;
                                r_victim_idx   <= r_ev_idx;
                                r_victim_rank  <= ev_rank;
                                r_victim_page  <= ram_rdata;
                            end
                        end else if (!r_empty_found) begin
                            r_empty_found <= 1'b1;
                            r_empty_idx   <= r_ev_idx;
                        end
                    end
                end

                S_UPDATE: begin
                    if (upd_fire) begin
                        // recency ranks
                        for (int i = 0; i < MAX_FRAMES; i++) begin
                            if (n_promote && r_valid[i] && (r_rank[i] > n_old_rank)) begin
                                r_rank[i] <= r_rank[i] - RANK_W'(1);
                            end
                            if (IDX_W'(i) == n_frame) begin
                                r_rank[i] <= n_promote ? n_top_rank
                                                       : RANK_W'(r_valid_cnt);
                            end
                        end
                        // fill an empty frame
                        if (!r_hit_found && r_empty_found) begin
                            r_valid[n_frame] <= 1'b1;
                            r_valid_cnt      <= r_valid_cnt + CNT_W'(1);
                        end
                        r_fault <= n_fault;

                        // result beat
                        r_out.hit           <= r_hit_found;
                        r_out.frame_index   <= FRAME_W'(n_frame);
                        r_out.evicted_valid <= !r_hit_found && !r_empty_found;
                        r_out.evicted_page  <= (!r_hit_found && !r_empty_found)
                                               ? PAGE_W'(r_victim_page) : '0;
                        r_out.fault_total   <= n_fault;
                        r_out.final_result  <= r_eos;
                        r_out_valid         <= 1'b1;
                        r_state             <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // fill count tracks the valid marks
    `LPR_ASSERT(a_cnt_matches, i_clk, i_rst_n, ($countones(r_valid) == int'(r_valid_cnt)))
    // scan never reads past the active frames
    `LPR_ASSERT(a_scan_bound, i_clk, i_rst_n, (r_state == S_SCAN) |-> (r_rd_idx <= r_lim))
    // a full miss always has a victim
    `LPR_NEVER(a_victim_seen, i_clk, i_rst_n, upd_fire && !r_hit_found && !r_empty_found && !r_victim_found)
    // fault count only drops on a start of string
    `LPR_ASSERT(a_fault_mono, i_clk, i_rst_n, (r_fault < $past(r_fault)) |-> $past(in_fire && i_in_data.start_of_string))
    // active frame count stays in range
    `LPR_NEVER(a_lim_range, i_clk, i_rst_n, (frames_lim == '0) || (int'(frames_lim) > MAX_FRAMES))

endmodule
